### rtl/htl_pkg.sv
// ----------------------------------------------------------------------------
// htl_pkg
// Shared types and constants of the tiled heightmap height lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package htl_pkg;

  // sizes
  localparam int NUM_TILES       = 4;
  localparam int MAX_GRID_POINTS = 256;
  localparam int STORE_DEPTH     = NUM_TILES * MAX_GRID_POINTS * MAX_GRID_POINTS;
  localparam int ADDR_W          = $clog2(STORE_DEPTH);
  localparam int HEIGHT_W        = 20;
  localparam int QUEUE_DEPTH     = 2;

  // divider: 8 cell bits plus 16 fraction bits
  localparam int QUOT_W   = 24;
  localparam int DIV_STEPS = QUOT_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);

  // item opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_PLACE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // configuration register indexes
  localparam logic CFG_TILE_SIZE   = 1'b0;
  localparam logic CFG_GRID_POINTS = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         tile;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [19:0] height_value;
    logic signed [3:0]  grid_x;
    logic signed [3:0]  grid_z;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [19:0] height;
    logic               covered;
    logic [1:0]         hit_tile;
  } out_t;

  // effective configuration: size never zero, grid points minus one in 1..255
  typedef struct packed {
    logic [11:0] size;
    logic [7:0]  gpm1;
  } cfg_t;

  // queue entry between front and back
  typedef struct packed {
    logic               is_query;
    logic               covered;
    logic [1:0]         tile;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [19:0] value;
    logic [19:0]        off_x;
    logic [19:0]        off_z;
  } qent_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_READ,
    BK_WEIGHT,
    BK_SUM,
    BK_DONE
  } bk_state_e;

endpackage

`default_nettype wire

### rtl/htl_ram.sv
// ----------------------------------------------------------------------------
// htl_ram
// Generic single port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module htl_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/htl_fifo.sv
// ----------------------------------------------------------------------------
// htl_fifo
// Short queue decoupling the classifying front from the lookup back end.
// ----------------------------------------------------------------------------
`default_nettype none

module htl_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire htl_pkg::qent_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output htl_pkg::qent_t     data_o
);
  import htl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_Q_W = $clog2(QUEUE_DEPTH + 1);

  qent_t               mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_q, rd_q;
  logic [CNT_Q_W-1:0]  count_q;

  assign full_o  = (count_q == CNT_Q_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_Q_W'(QUEUE_DEPTH)) else $error("queue level out of range");

endmodule

`default_nettype wire

### rtl/htl_front.sv
// ----------------------------------------------------------------------------
// htl_front
// Accepts items, keeps tile placement, finds the covering tile of a query.
// ----------------------------------------------------------------------------
`default_nettype none

module htl_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire htl_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire htl_pkg::in_t  in_data_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output htl_pkg::qent_t     q_data_o
);
  import htl_pkg::*;

  logic signed [3:0] org_x_q [NUM_TILES];
  logic signed [3:0] org_z_q [NUM_TILES];
  logic              valid_q [NUM_TILES];

  logic               accept;
  logic               tile_ok;
  logic signed [12:0] size_s;
  logic signed [24:0] px, pz;
  logic               hit;
  logic [1:0]         hit_tile;
  logic [19:0]        off_x, off_z;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tile_ok    = int'(in_data_i.tile) < NUM_TILES;
  assign size_s     = $signed({1'b0, cfg_i.size});
  assign px         = in_data_i.pos_x;
  assign pz         = in_data_i.pos_z;

  // tile search, lowest valid covering index wins
  always_comb begin
    logic signed [16:0] lo_x, lo_z, hi_x, hi_z;
    logic signed [24:0] lo_x8, lo_z8, hi_x8, hi_z8, dx, dz;
    hit      = 1'b0;
    hit_tile = '0;
    off_x    = '0;
    off_z    = '0;
    for (int k = NUM_TILES - 1; k >= 0; k--) begin
      lo_x  = org_x_q[k] * size_s;
      lo_z  = org_z_q[k] * size_s;
      hi_x  = lo_x + size_s;
      hi_z  = lo_z + size_s;
      lo_x8 = $signed({lo_x, 8'd0});
      lo_z8 = $signed({lo_z, 8'd0});
      hi_x8 = $signed({hi_x, 8'd0});
      hi_z8 = $signed({hi_z, 8'd0});
      dx    = px - lo_x8;
      dz    = pz - lo_z8;
      if (valid_q[k] && px >= lo_x8 && px < hi_x8 && pz >= lo_z8 && pz < hi_z8) begin
        hit      = 1'b1;
        hit_tile = 2'(k);
        off_x    = dx[19:0];
        off_z    = dz[19:0];
      end
    end
  end

  // queue entry
  always_comb begin
    q_data_o          = '0;
    q_data_o.is_query = (in_data_i.opcode == OP_QUERY);
    q_data_o.covered  = hit;
    q_data_o.tile     = (in_data_i.opcode == OP_QUERY) ? hit_tile : in_data_i.tile;
    q_data_o.row      = in_data_i.row;
    q_data_o.col      = in_data_i.col;
    q_data_o.value    = in_data_i.height_value;
    q_data_o.off_x    = off_x;
    q_data_o.off_z    = off_z;
    q_push_o = accept && ((in_data_i.opcode == OP_WRITE && tile_ok) ||
                          in_data_i.opcode == OP_QUERY);
  end

  // tile placement
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_TILES; k++) begin
        org_x_q[k] <= '0;
        org_z_q[k] <= '0;
        valid_q[k] <= 1'b0;
      end
    end else if (accept && in_data_i.opcode == OP_PLACE && tile_ok) begin
      org_x_q[in_data_i.tile] <= in_data_i.grid_x;
      org_z_q[in_data_i.tile] <= in_data_i.grid_z;
      valid_q[in_data_i.tile] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/htl_back.sv
// ----------------------------------------------------------------------------
// htl_back
// Executes sample writes and queries: cell divide, sample reads, interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module htl_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire htl_pkg::cfg_t  cfg_i,
  input  wire logic           q_empty_i,
  input  wire htl_pkg::qent_t q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output htl_pkg::out_t       out_data_o
);
  import htl_pkg::*;

  localparam logic [16:0] ONE = 17'h10000;

  bk_state_e state_q, state_d;

  qent_t               ent_q;
  logic [19:0]         remx_q, remz_q;
  logic [QUOT_W-1:0]   dvx_q, dvz_q;
  logic [QUOT_W-1:0]   qx_q, qz_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [2:0]          rd_cnt_q;
  logic signed [19:0]  h_q [4];
  logic signed [37:0]  p0_q, p1_q, p2_q;
  logic signed [37:0]  sa_q, sb_q;
  logic                out_valid_q;
  out_t                out_q;

  logic [19:0]         den;
  logic [27:0]         nx, nz;
  logic [20:0]         rx21, rz21;
  logic                gex, gez;
  logic [7:0]          ix, iz;
  logic [15:0]         xc, zc;
  logic                lower;
  logic                out_free;
  logic                ram_en, ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [19:0]         ram_rdata;

  assign den      = {cfg_i.size, 8'd0};
  assign nx       = ent_q.off_x * cfg_i.gpm1;
  assign nz       = ent_q.off_z * cfg_i.gpm1;
  assign rx21     = {remx_q, dvx_q[QUOT_W-1]};
  assign rz21     = {remz_q, dvz_q[QUOT_W-1]};
  assign gex      = rx21 >= {1'b0, den};
  assign gez      = rz21 >= {1'b0, den};
  assign ix       = qx_q[23:16];
  assign iz       = qz_q[23:16];
  assign xc       = qx_q[15:0];
  assign zc       = qz_q[15:0];
  assign lower    = ({1'b0, xc} + {1'b0, zc}) <= ONE;
  assign out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && q_data_i.is_query) begin
          state_d = q_data_i.covered ? BK_MUL : BK_DONE;
        end
      end
      BK_MUL:    state_d = BK_DIV;
      BK_DIV:    if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = BK_READ;
      BK_READ:   if (rd_cnt_q == 3'd4) state_d = BK_WEIGHT;
      BK_WEIGHT: state_d = BK_SUM;
      BK_SUM:    state_d = BK_DONE;
      BK_DONE:   if (out_free) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // queue pop and store access
  always_comb begin
    q_pop_o  = 1'b0;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = ADDR_W'({q_data_i.tile, q_data_i.row, q_data_i.col});
    unique case (state_q)
      BK_IDLE: begin
        q_pop_o = !q_empty_i;
        ram_en  = !q_empty_i && !q_data_i.is_query;
        ram_we  = 1'b1;
      end
      BK_READ: begin
        ram_en = rd_cnt_q != 3'd4;
        case (rd_cnt_q[1:0])
          2'd0:    ram_addr = ADDR_W'({ent_q.tile, ix, iz});
          2'd1:    ram_addr = ADDR_W'({ent_q.tile, 8'(ix + 8'd1), iz});
          2'd2:    ram_addr = ADDR_W'({ent_q.tile, ix, 8'(iz + 8'd1)});
          default: ram_addr = ADDR_W'({ent_q.tile, 8'(ix + 8'd1), 8'(iz + 8'd1)});
        endcase
      end
      default: ;
    endcase
  end

  htl_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (q_data_i.value),
    .rdata_o (ram_rdata)
  );

  // datapath
  always_ff @(posedge clk_i) begin
    logic [16:0] w0, w1, w2;
    logic signed [19:0] ha, hb, hc;
    case (state_q)
      BK_IDLE: begin
        ent_q <= q_data_i;
      end
      BK_MUL: begin
        remx_q <= nx[27:8];
        remz_q <= nz[27:8];
        dvx_q  <= {nx[7:0], 16'd0};
        dvz_q  <= {nz[7:0], 16'd0};
        cnt_q  <= '0;
      end
      BK_DIV: begin
        remx_q   <= gex ? 20'(rx21 - {1'b0, den}) : rx21[19:0];
        remz_q   <= gez ? 20'(rz21 - {1'b0, den}) : rz21[19:0];
        dvx_q    <= {dvx_q[QUOT_W-2:0], 1'b0};
        dvz_q    <= {dvz_q[QUOT_W-2:0], 1'b0};
        qx_q     <= {qx_q[QUOT_W-2:0], gex};
        qz_q     <= {qz_q[QUOT_W-2:0], gez};
        cnt_q    <= cnt_q + 1'b1;
        rd_cnt_q <= '0;
      end
      BK_READ: begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
        if (rd_cnt_q != 3'd0) begin
          h_q[2'(rd_cnt_q - 3'd1)] <= ram_rdata;
        end
      end
      BK_WEIGHT: begin
        // lower triangle uses h00 h10 h01, upper uses h10 h11 h01
        if (lower) begin
          w0 = ONE - {1'b0, xc} - {1'b0, zc};
          w1 = {1'b0, xc};
          w2 = {1'b0, zc};
          ha = h_q[0];
          hb = h_q[1];
          hc = h_q[2];
        end else begin
          w0 = ONE - {1'b0, zc};
          w1 = {1'b0, xc} + {1'b0, zc} - ONE;
          w2 = ONE - {1'b0, xc};
          ha = h_q[1];
          hb = h_q[3];
          hc = h_q[2];
        end
        p0_q <= $signed({1'b0, w0}) * ha;
        p1_q <= $signed({1'b0, w1}) * hb;
        p2_q <= $signed({1'b0, w2}) * hc;
      end
      BK_SUM: begin
        sa_q <= p0_q + p1_q;
        sb_q <= p2_q + 38'sd32768;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    logic signed [37:0] s;
    s = sa_q + sb_q;
    if (state_q == BK_DONE && out_free) begin
      out_q.covered  <= ent_q.covered;
      out_q.hit_tile <= ent_q.covered ? ent_q.tile : 2'd0;
      out_q.height   <= ent_q.covered ? s[35:16] : 20'sd0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == BK_IDLE) else $error("pop outside idle");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIV |-> (remx_q < den && remz_q < den))
    else $error("divider remainder out of range");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == BK_DONE)) else $error("stray result");

endmodule

`default_nettype wire

### rtl/tiled_heightmap_height_lookup_unit.sv
// ----------------------------------------------------------------------------
// tiled_heightmap_height_lookup_unit
// Terrain height lookup over several placed heightmap tiles.
// ----------------------------------------------------------------------------
// Input beats carry a sample write, a tile placement or a query. A query
// returns one output beat (height, covered, hit_tile); other beats return
// nothing. Configuration beats set tile_size (index 0) and grid_points
// (index 1); the configuration port is always ready.
// The front checks all tiles at once in the acceptance cycle and pushes
// writes and queries into a two entry queue. The back end takes one entry
// at a time: a write is stored in the cycle it is popped; a covered query
// runs pop, multiply, 24 steps of the bit serial cell divider, four
// sample reads through the single store port, weighting, summing and
// loading the result register; an uncovered query goes from pop straight
// to loading the result register. The divider sets the throughput.
// Reset clears placement and configuration (tile_size 800, grid_points
// 256); the height store is not cleared. When the receiver stalls the
// result waits in the output register, the back end holds, and input beats
// are still taken until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_heightmap_height_lookup_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire htl_pkg::in_t in_data_i,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_addr_i,
  input  wire logic [11:0]  cfg_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output htl_pkg::out_t     out_data_o
);
  import htl_pkg::*;

  logic [11:0] tile_size_q;
  logic [8:0]  grid_points_q;
  cfg_t        cfg;
  logic        q_full, q_empty, q_push, q_pop;
  qent_t       q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q   <= 12'd800;
      grid_points_q <= 9'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_TILE_SIZE:   tile_size_q   <= cfg_data_i;
        CFG_GRID_POINTS: grid_points_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // effective size and clamped grid spacing count
  always_comb begin
    cfg.size = (tile_size_q == '0) ? 12'd1 : tile_size_q;
    if (grid_points_q < 9'd2) begin
      cfg.gpm1 = 8'd1;
    end else if (grid_points_q > 9'(MAX_GRID_POINTS)) begin
      cfg.gpm1 = 8'(MAX_GRID_POINTS - 1);
    end else begin
      cfg.gpm1 = 8'(grid_points_q - 9'd1);
    end
  end

  htl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  htl_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  htl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
